/* rtl/core/bss_pkg.sv */
`default_nettype none

package bss_pkg;

    // Configuration register widths and reset values.
    localparam int DEGREE_W    = 3;
    localparam int SAMPLES_W   = 7;
    localparam int DEGREE_RST  = 3;
    localparam int SAMPLES_RST = 16;

    // Configuration port geometry: two 32-bit registers at byte addresses 0 and 4.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index as decoded from the word-select address bit.
    localparam logic REG_DEGREE  = 1'b0;
    localparam logic REG_SAMPLES = 1'b1;

    typedef logic [DEGREE_W-1:0]   t_degree;
    typedef logic [SAMPLES_W-1:0]  t_samples;
    typedef logic [APB_ADDR_W-1:0] t_apb_addr;
    typedef logic [APB_DATA_W-1:0] t_apb_data;

endpackage

`default_nettype wire

/* rtl/core/bss_point_if.sv */
`default_nettype none

interface bss_point_if #(
    parameter int COORD_WIDTH = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic                          last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/bss_curve_if.sv */
`default_nettype none

interface bss_curve_if #(
    parameter int COORD_WIDTH = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] curve_x;
    logic signed [COORD_WIDTH-1:0] curve_y;
    logic                          run_end;

    modport source (output valid, output curve_x, output curve_y, output run_end,
                    input ready);
    modport sink (input valid, input curve_x, input curve_y, input run_end,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/bss_tdiv.sv */
`default_nettype none

// Restoring divider for the curve parameter: t = floor((k << F) / d).
// One quotient bit per cycle; the quotient holds after busy falls.
module bss_tdiv #(
    parameter int KW = 6,
    parameter int F  = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [KW-1:0] i_k,
    input  wire logic [KW-1:0] i_d,
    output logic               o_busy,
    output logic [F:0]         o_t
);
    localparam int DW = KW + F;
    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_num;
    logic [KW:0]   r_rem;
    logic [DW-1:0] r_quo;

    logic [KW:0] rem_sh;
    logic        rem_ge;

    // Bring down the next dividend bit and try the subtraction.
    always_comb begin
        rem_sh = {r_rem[KW-1:0], r_num[DW-1]};
        rem_ge = (rem_sh >= {1'b0, i_d});
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == CW'(1)) begin
            r_busy <= 1'b0;
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CW'(DW);
            r_num <= {i_k, {F{1'b0}}};
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_num <= {r_num[DW-2:0], 1'b0};
            r_rem <= rem_ge ? (rem_sh - {1'b0, i_d}) : rem_sh;
            r_quo <= {r_quo[DW-2:0], rem_ge};
        end
    end

    assign o_busy = r_busy;
    // The quotient never exceeds 2^F, so its upper bits are zero.
    assign o_t    = r_quo[F:0];

endmodule

`default_nettype wire

/* rtl/core/bss_lerp.sv */
`default_nettype none

// Shared interpolation unit, one lane per coordinate:
// r = a + floor((b - a) * t / 2^F). The product is registered, the add follows.
module bss_lerp #(
    parameter int W = 16,
    parameter int F = 16
) (
    input  wire logic                 i_clk,
    input  wire logic signed [W-1:0]  i_ax,
    input  wire logic signed [W-1:0]  i_bx,
    input  wire logic signed [W-1:0]  i_ay,
    input  wire logic signed [W-1:0]  i_by,
    input  wire logic        [F:0]    i_t,
    output logic signed [W-1:0]       o_rx,
    output logic signed [W-1:0]       o_ry
);
    localparam int PW = W + F + 3;

    logic signed [W:0]    dx;
    logic signed [W:0]    dy;
    logic signed [F+1:0]  ts;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;

    logic signed [W-1:0] r_ax;
    logic signed [W-1:0] r_ay;
    logic signed [W-1:0] r_fx;
    logic signed [W-1:0] r_fy;

    // Difference and scaled product; the arithmetic shift by F is a floor.
    always_comb begin
        dx = $signed({i_bx[W-1], i_bx}) - $signed({i_ax[W-1], i_ax});
        dy = $signed({i_by[W-1], i_by}) - $signed({i_ay[W-1], i_ay});
        ts = $signed({1'b0, i_t});
        px = dx * ts;
        py = dy * ts;
    end

    // The result lies between a and b, so the low W bits of the step suffice.
    always_ff @(posedge i_clk) begin
        r_ax <= i_ax;
        r_ay <= i_ay;
        r_fx <= px[F +: W];
        r_fy <= py[F +: W];
    end

    assign o_rx = r_ax + r_fx;
    assign o_ry = r_ay + r_fy;

endmodule

`default_nettype wire

/* rtl/core/bezier_spline_sampler.sv */
// A point that does not complete a segment is taken with no result.
// A completing point yields its samples in turn: for each, the bit-serial divider forms t
// as the segment loads, then the lerp unit (product registered, then add) folds each level.
// Throughput: one point at a time; input ready is low until the last sample is registered.
// Reset: synchronous, active low; clears the point count and output valid, sets the
// first-segment flag and loads degree 3 and 16 samples; the point stores need no clear.
`default_nettype none

module bezier_spline_sampler #(
    parameter int MAX_DEGREE  = 7,
    parameter int MAX_SAMPLES = 64,
    parameter int COORD_WIDTH = 16,
    parameter int T_FRAC_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    bss_point_if.sink                i_point,
    bss_curve_if.source              o_curve,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire bss_pkg::t_apb_addr  paddr,
    input  wire bss_pkg::t_apb_data  pwdata,
    output bss_pkg::t_apb_data       prdata,
    output logic                     pready
);
    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam int KW    = $clog2(MAX_SAMPLES);
    localparam int W     = COORD_WIDTH;
    localparam int F     = T_FRAC_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TDIV  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_TWAIT = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_ADD   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]         r_state, n_state;
    bss_pkg::t_degree   r_degree, n_degree;
    bss_pkg::t_samples  r_samples, n_samples;
    logic [IW-1:0]      r_pis, n_pis;
    logic               r_first, n_first;
    logic               r_out_valid, n_out_valid;

    logic               r_last, n_last;
    logic [2*W-1:0]     r_new, n_new;
    logic [IW-1:0]      r_base, n_base;
    logic [IW-1:0]      r_ld, n_ld;
    logic [IW-1:0]      r_lvl, n_lvl;
    logic [IW-1:0]      r_step, n_step;
    logic [KW-1:0]      r_k, n_k;
    logic signed [W-1:0] r_cx, n_cx;
    logic signed [W-1:0] r_cy, n_cy;
    logic               r_rend, n_rend;

    logic [2*W-1:0]     r_held [DEPTH];
    logic [2*W-1:0]     n_held [DEPTH];
    logic [2*W-1:0]     r_work [DEPTH];
    logic [2*W-1:0]     n_work [DEPTH];
    logic [2*W-1:0]     w_ext  [DEPTH+2];

    logic [IW-1:0]      deg_eff;
    bss_pkg::t_samples  n_eff;
    logic [KW-1:0]      div_d;
    logic               in_acc;
    logic               cfg_wr;
    logic [IW-1:0]      rd_addr;
    logic [2*W-1:0]     held_rd;
    logic               lerp_last;
    logic [IW-1:0]      wr_pos;
    logic               div_start;
    logic               div_busy;
    logic [F:0]         div_t;
    logic signed [W-1:0] lerp_x;
    logic signed [W-1:0] lerp_y;

    assign in_acc = i_point.valid && i_point.ready;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Effective degree and sample count, clamped to the supported range.
    always_comb begin
        if (int'(r_degree) > MAX_DEGREE) begin
            deg_eff = IW'(MAX_DEGREE);
        end else if (r_degree == '0) begin
            deg_eff = IW'(1);
        end else begin
            deg_eff = IW'(r_degree);
        end
        if (int'(r_samples) < 2) begin
            n_eff = bss_pkg::t_samples'(2);
        end else if (int'(r_samples) > MAX_SAMPLES) begin
            n_eff = bss_pkg::t_samples'(MAX_SAMPLES);
        end else begin
            n_eff = r_samples;
        end
        div_d = KW'(n_eff - 1'b1);
    end

    // Single read port on the control point store.
    assign rd_addr = r_base + r_ld;
    assign held_rd = r_held[rd_addr];

    // Scratch queue seen with two padding entries, so a shift by two stays in range.
    genvar g;
    generate
        for (g = 0; g < DEPTH + 2; g++) begin : g_ext
            if (g < DEPTH) begin : g_real
                assign w_ext[g] = r_work[g];
            end else begin : g_pad
                assign w_ext[g] = '0;
            end
        end
    endgenerate

    // The last lerp of a level drops the stale tail entry along with the consumed head.
    assign lerp_last = (r_step == r_lvl - 1'b1);
    assign wr_pos    = lerp_last ? (r_lvl - 1'b1) : r_lvl;

    bss_tdiv #(
        .KW (KW),
        .F  (F)
    ) u_bss_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_k     (r_k),
        .i_d     (div_d),
        .o_busy  (div_busy),
        .o_t     (div_t)
    );

    bss_lerp #(
        .W (W),
        .F (F)
    ) u_bss_lerp (
        .i_clk (i_clk),
        .i_ax  (r_work[0][2*W-1:W]),
        .i_bx  (r_work[1][2*W-1:W]),
        .i_ay  (r_work[0][W-1:0]),
        .i_by  (r_work[1][W-1:0]),
        .i_t   (div_t),
        .o_rx  (lerp_x),
        .o_ry  (lerp_y)
    );

    // Sequencer and next-state logic.
    always_comb begin
        n_state     = r_state;
        n_degree    = r_degree;
        n_samples   = r_samples;
        n_pis       = r_pis;
        n_first     = r_first;
        n_out_valid = r_out_valid && !o_curve.ready;
        n_last      = r_last;
        n_new       = r_new;
        n_base      = r_base;
        n_ld        = r_ld;
        n_lvl       = r_lvl;
        n_step      = r_step;
        n_k         = r_k;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_rend      = r_rend;
        n_held      = r_held;
        n_work      = r_work;
        div_start   = 1'b0;

        // Configuration writes.
        if (cfg_wr) begin
            case (paddr[2])
                bss_pkg::REG_DEGREE: begin
                    n_degree = pwdata[bss_pkg::DEGREE_W-1:0];
                end
                bss_pkg::REG_SAMPLES: begin
                    n_samples = pwdata[bss_pkg::SAMPLES_W-1:0];
                end
                default: begin
                end
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_held[r_pis] = {i_point.point_x, i_point.point_y};
                    n_new         = {i_point.point_x, i_point.point_y};
                    n_last        = i_point.last_point;
                    if (r_pis >= deg_eff) begin
                        // Segment complete: evaluate the newest degree+1 points.
                        n_base  = r_pis - deg_eff;
                        n_k     = r_first ? '0 : KW'(1);
                        n_state = S_TDIV;
                    end else if (i_point.last_point) begin
                        n_pis   = '0;
                        n_first = 1'b1;
                    end else begin
                        n_pis = r_pis + 1'b1;
                    end
                end
            end
            S_TDIV: begin
                div_start = 1'b1;
                n_ld      = '0;
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                // Copy the segment into the scratch queue while t is divided out.
                n_work[r_ld] = held_rd;
                if (r_ld == deg_eff) begin
                    n_lvl   = deg_eff;
                    n_step  = '0;
                    n_state = S_TWAIT;
                end else begin
                    n_ld = r_ld + 1'b1;
                end
            end
            S_TWAIT: begin
                if (!div_busy) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                // Pop the consumed head and append the interpolated point.
                for (int j = 0; j < DEPTH; j++) begin
                    n_work[j] = lerp_last ? w_ext[j+2] : w_ext[j+1];
                end
                n_work[wr_pos] = {lerp_x, lerp_y};
                if (lerp_last) begin
                    if (r_lvl == IW'(1)) begin
                        n_state = S_EMIT;
                    end else begin
                        n_lvl   = r_lvl - 1'b1;
                        n_step  = '0;
                        n_state = S_MUL;
                    end
                end else begin
                    n_step  = r_step + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || o_curve.ready) begin
                    n_out_valid = 1'b1;
                    n_cx        = r_work[0][2*W-1:W];
                    n_cy        = r_work[0][W-1:0];
                    n_rend      = (r_k == div_d);
                    if (r_k == div_d) begin
                        // Newest point starts the next segment, unless the spline ends.
                        n_held[0] = r_new;
                        n_pis     = r_last ? '0 : IW'(1);
                        n_first   = r_last;
                        n_state   = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_TDIV;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_degree    <= bss_pkg::t_degree'(bss_pkg::DEGREE_RST);
            r_samples   <= bss_pkg::t_samples'(bss_pkg::SAMPLES_RST);
            r_pis       <= '0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_degree    <= n_degree;
            r_samples   <= n_samples;
            r_pis       <= n_pis;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and point stores.
    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_new  <= n_new;
        r_base <= n_base;
        r_ld   <= n_ld;
        r_lvl  <= n_lvl;
        r_step <= n_step;
        r_k    <= n_k;
        r_cx   <= n_cx;
        r_cy   <= n_cy;
        r_rend <= n_rend;
        r_held <= n_held;
        r_work <= n_work;
    end

    // Channel outputs.
    assign i_point.ready   = (r_state == S_IDLE);
    assign o_curve.valid   = r_out_valid;
    assign o_curve.curve_x = r_cx;
    assign o_curve.curve_y = r_cy;
    assign o_curve.run_end = r_rend;

    // Register readback.
    always_comb begin
        case (paddr[2])
            bss_pkg::REG_DEGREE:  prdata = bss_pkg::t_apb_data'(r_degree);
            bss_pkg::REG_SAMPLES: prdata = bss_pkg::t_apb_data'(r_samples);
            default:              prdata = '0;
        endcase
    end
    assign pready = 1'b1;

endmodule

`default_nettype wire

/* rtl/core/bss_checker.sv */
`default_nettype none

module bss_checker #(
    parameter int COORD_WIDTH = 16
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic signed [COORD_WIDTH-1:0] i_curve_x,
    input wire logic signed [COORD_WIDTH-1:0] i_curve_y,
    input wire logic                          i_run_end,
    input wire logic                          i_psel,
    input wire logic                          i_penable,
    input wire logic                          i_pwrite,
    input wire logic                          i_pready,
    input wire bss_pkg::t_apb_addr            i_paddr,
    input wire bss_pkg::t_apb_data            i_pwdata,
    input wire bss_pkg::t_apb_data            i_prdata
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_curve_x) && $stable(i_curve_y) && $stable(i_run_end))
        else $error("result payload changed while stalled");

    // A fresh result is only produced while the block is evaluating a segment.
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !$past(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared while the point input was open");

    // A degree write reads back on the following cycle.
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_psel && i_penable && i_pwrite && i_pready && i_paddr[2] == bss_pkg::REG_DEGREE)
            ##1 (i_paddr[2] == bss_pkg::REG_DEGREE)
        |-> i_prdata == bss_pkg::t_apb_data'($past(i_pwdata[bss_pkg::DEGREE_W-1:0])))
        else $error("degree register readback mismatch");

endmodule

bind bezier_spline_sampler bss_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_bss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_point.ready),
    .i_out_valid (o_curve.valid),
    .i_out_ready (o_curve.ready),
    .i_curve_x   (o_curve.curve_x),
    .i_curve_y   (o_curve.curve_y),
    .i_run_end   (o_curve.run_end),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_pready    (pready),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata)
);

`default_nettype wire
